// ===== rtl/rgb_to_hsv_convert_assert.svh =====
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on the same edge.
`define RHC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rgb_to_hsv_convert: check failed");
// Implication checked on the next edge.
`define RHC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rgb_to_hsv_convert: check failed");
`else
`define RHC_ASSERT_NOW(label, clk, rst, pre, post)
`define RHC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/rhc_pkg.sv =====
// Types and constants shared by the RGB to HSV converter.
package rhc_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int FRAC_BITS    = 16;

   // Sextant constants 0.17, 0.33, 0.67 in Q0.FRAC_BITS, rounded to nearest
   localparam logic [FRAC_BITS-1:0] SEXT_C17 =
      FRAC_BITS'((17 * (2 ** FRAC_BITS) + 50) / 100);
   localparam logic [FRAC_BITS-1:0] SEXT_C33 =
      FRAC_BITS'((33 * (2 ** FRAC_BITS) + 50) / 100);
   localparam logic [FRAC_BITS-1:0] SEXT_C67 =
      FRAC_BITS'((67 * (2 ** FRAC_BITS) + 50) / 100);

   // which channel holds the maximum
   localparam logic [1:0] SEXT_RED   = 2'd0;
   localparam logic [1:0] SEXT_GREEN = 2'd1;
   localparam logic [1:0] SEXT_BLUE  = 2'd2;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0]    hue;
      logic [FRAC_BITS-1:0]    saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } rsp_type;

   // state carried along the divider chain
   typedef struct packed {
      logic                    valid;
      logic [CHANNEL_BITS-1:0] brightness;
      logic [CHANNEL_BITS-1:0] sat_div;
      logic [CHANNEL_BITS-1:0] hue_div;
      logic [CHANNEL_BITS-1:0] sat_rem;
      logic [CHANNEL_BITS-1:0] hue_rem;
      logic [FRAC_BITS-1:0]    hue_low;
      logic [FRAC_BITS-1:0]    sat_q;
      logic [FRAC_BITS-1:0]    hue_q;
      logic [1:0]              sextant;
      logic                    neg;
      logic                    sat_zero;
      logic                    sat_full;
      logic                    hue_zero;
   } cell_type;

endpackage

// ===== rtl/rhc_front.sv =====
// Front end: max/min, sextant select, hue numerator product, divider seed.
module rhc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rhc_pkg::req_type   in_data,
   output rhc_pkg::cell_type  out
);
   localparam int CB = rhc_pkg::CHANNEL_BITS;
   localparam int FB = rhc_pkg::FRAC_BITS;

   typedef struct packed {
      logic          valid;
      logic [CB-1:0] mx;
      logic [CB-1:0] d;
      logic [CB-1:0] mag;
      logic [1:0]    sextant;
      logic          neg;
   } s1_type;

   s1_type                s1_ff, s1_in;
   rhc_pkg::cell_type     seed_ff, seed_in;
   logic [CB-1:0]         r, g, b, mn;
   logic [FB+CB-1:0]      prod;

   always_comb begin
      r = in_data.red;
      g = in_data.green;
      b = in_data.blue;
      s1_in       = '0;
      s1_in.valid = in_valid;
      if (r >= g && r >= b) begin
         s1_in.sextant = rhc_pkg::SEXT_RED;
         s1_in.mx      = r;
         mn            = (g < b) ? g : b;
         s1_in.neg     = b > g;
         s1_in.mag     = (b > g) ? CB'(b - g) : CB'(g - b);
      end else if (g >= b) begin
         s1_in.sextant = rhc_pkg::SEXT_GREEN;
         s1_in.mx      = g;
         mn            = (r < b) ? r : b;
         s1_in.neg     = r > b;
         s1_in.mag     = (r > b) ? CB'(r - b) : CB'(b - r);
      end else begin
         s1_in.sextant = rhc_pkg::SEXT_BLUE;
         s1_in.mx      = b;
         mn            = (r < g) ? r : g;
         s1_in.neg     = g > r;
         s1_in.mag     = (g > r) ? CB'(g - r) : CB'(r - g);
      end
      s1_in.d = CB'(s1_in.mx - mn);
   end

   // C17 * |numerator|; upper bits seed the hue remainder
   assign prod = {{CB{1'b0}}, rhc_pkg::SEXT_C17} * {{FB{1'b0}}, s1_ff.mag};

   always_comb begin
      seed_in            = '0;
      seed_in.valid      = s1_ff.valid;
      seed_in.brightness = s1_ff.mx;
      seed_in.sat_div    = s1_ff.mx;
      seed_in.hue_div    = s1_ff.d;
      seed_in.sat_rem    = s1_ff.d;
      seed_in.hue_rem    = prod[FB+CB-1:FB];
      seed_in.hue_low    = prod[FB-1:0];
      seed_in.sextant    = s1_ff.sextant;
      seed_in.neg        = s1_ff.neg;
      seed_in.sat_zero   = s1_ff.mx == '0;
      seed_in.sat_full   = (s1_ff.d == s1_ff.mx) && (s1_ff.mx != '0);
      seed_in.hue_zero   = s1_ff.d == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         seed_ff <= '0;
      end else begin
         s1_ff   <= s1_in;
         seed_ff <= seed_in;
      end
   end

   assign out = seed_ff;

endmodule

// ===== rtl/rhc_div_cell.sv =====
// One restoring-division cell: one saturation and one hue quotient bit.
`include "rgb_to_hsv_convert_assert.svh"

module rhc_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  rhc_pkg::cell_type  cell_in,
   output rhc_pkg::cell_type  cell_out
);
   localparam int CB = rhc_pkg::CHANNEL_BITS;
   localparam int FB = rhc_pkg::FRAC_BITS;

   rhc_pkg::cell_type  cell_ff, cell_in_next;
   logic [CB:0]        sat_t, hue_t;
   logic               sat_ge, hue_ge;

   always_comb begin
      sat_t  = {cell_in.sat_rem, 1'b0};
      hue_t  = {cell_in.hue_rem, cell_in.hue_low[FB-1]};
      sat_ge = sat_t >= {1'b0, cell_in.sat_div};
      hue_ge = hue_t >= {1'b0, cell_in.hue_div};

      cell_in_next         = cell_in;
      cell_in_next.sat_rem = sat_ge ? CB'(sat_t - {1'b0, cell_in.sat_div}) : sat_t[CB-1:0];
      cell_in_next.hue_rem = hue_ge ? CB'(hue_t - {1'b0, cell_in.hue_div}) : hue_t[CB-1:0];
      cell_in_next.hue_low = {cell_in.hue_low[FB-2:0], 1'b0};
      cell_in_next.sat_q   = {cell_in.sat_q[FB-2:0], sat_ge};
      cell_in_next.hue_q   = {cell_in.hue_q[FB-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

   `RHC_ASSERT_NEXT(a_valid_moves, clock, reset, cell_in.valid, cell_ff.valid)
   `RHC_ASSERT_NOW(a_sat_rem_bound, clock, reset, cell_ff.valid && !cell_ff.sat_zero && !cell_ff.sat_full, cell_ff.sat_rem < cell_ff.sat_div)
   `RHC_ASSERT_NOW(a_hue_rem_bound, clock, reset, cell_ff.valid && !cell_ff.hue_zero, cell_ff.hue_rem < cell_ff.hue_div)

endmodule

// ===== rtl/rgb_to_hsv_convert.sv =====
// RGB to HSV converter top level: front end, divider cell chain, output stage.
// Pipeline: two front stages, one division cell per quotient bit, one output stage.
// Throughput: one transaction per clock outside reset; the division cell chain is fully pipelined.
// Reset: synchronous, active high, clears all valid bits; busy is high only during reset.
// The receiver cannot stall: rsp_strobe marks each result for exactly one cycle.
`include "rgb_to_hsv_convert_assert.svh"

module rgb_to_hsv_convert (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rhc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output rhc_pkg::rsp_type  rsp_data
);
   localparam int FB = rhc_pkg::FRAC_BITS;

   // chain[0] is the seeded divider state, chain[FB] holds finished quotients
   rhc_pkg::cell_type  chain [FB+1];
   rhc_pkg::cell_type  tail;
   rhc_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               accept;
   logic [FB-1:0]      hue_term, hue_base;

   // no backpressure on either side; only reset holds off new transactions
   assign busy   = reset;
   assign accept = start && !busy;

   rhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .out      (chain[0])
   );

   // one quotient bit per cell for both dividers
   for (genvar i = 0; i < FB; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign tail = chain[FB];

   always_comb begin
      // truncation toward zero: divide the magnitude, then restore the sign
      hue_term = tail.neg ? FB'(~tail.hue_q + 1'b1) : tail.hue_q;
      unique case (tail.sextant)
         rhc_pkg::SEXT_RED:   hue_base = '0;
         rhc_pkg::SEXT_GREEN: hue_base = rhc_pkg::SEXT_C33;
         rhc_pkg::SEXT_BLUE:  hue_base = rhc_pkg::SEXT_C67;
         default:             hue_base = '0;
      endcase

      rsp_strobe_in          = tail.valid;
      rsp_data_in.brightness = tail.brightness;
      // modular add also does the wrap of a negative hue
      rsp_data_in.hue        = tail.hue_zero ? '0 : FB'(hue_base + hue_term);
      if (tail.sat_zero) begin
         rsp_data_in.saturation = '0;
      end else if (tail.sat_full) begin
         rsp_data_in.saturation = '1;
      end else begin
         rsp_data_in.saturation = tail.sat_q;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `RHC_ASSERT_NOW(a_black_pixel, clock, reset, rsp_strobe_ff && rsp_data_ff.brightness == '0, rsp_data_ff.saturation == '0 && rsp_data_ff.hue == '0)
   `RHC_ASSERT_NEXT(a_tail_to_output, clock, reset, tail.valid, rsp_strobe_ff)
   `RHC_ASSERT_NOW(a_gray_hue, clock, reset, tail.valid && tail.hue_zero, rsp_data_in.hue == '0 && rsp_data_in.saturation != '1)

endmodule

// ===== bench/rgb_to_hsv_convert_tb.sv =====
// Self-checking testbench for the pipelined RGB to HSV converter.
module rgb_to_hsv_convert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = rhc_pkg::FRAC_BITS;
   localparam int CB = rhc_pkg::CHANNEL_BITS;

   // pipeline depth from the accepting edge to the result edge
   localparam int LATENCY     = FB + 3;
   localparam int CHANNEL_MAX = (1 << CB) - 1;
   localparam int RANDOM_PIXELS = 1950;
   // the final stretch of the stream is driven back to back
   localparam int QUIET_TAIL  = 200;

   // hue sextant constants, Q0.FRAC_BITS, rounded to nearest
   localparam longint HUE_ONE  = longint'(1) << FB;
   localparam longint HUE_MASK = HUE_ONE - 1;
   localparam longint HUE_C17  = (17 * HUE_ONE + 50) / 100;
   localparam longint HUE_C33  = (33 * HUE_ONE + 50) / 100;
   localparam longint HUE_C67  = (67 * HUE_ONE + 50) / 100;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   logic             busy;
   rhc_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   rhc_pkg::rsp_type rsp_data;

   rhc_pkg::req_type pixel_q[$];        // pixels waiting to be offered
   rhc_pkg::rsp_type hsv_expected_q[$]; // predicted results, oldest first
   int      gap_left  = 0;     // idle cycles left in the current burst
   int      calm_left = 0;     // pixels left in a stretch with no idling
   int      error_count = 0;

   rgb_to_hsv_convert DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hold reset from time zero, then release it for good.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Predict hue, saturation and value for one pixel.
   // Max ties go to red, then green. The sextant term is truncated toward
   // zero (signed division), and a negative hue wraps by one full circle.
   function automatic rhc_pkg::rsp_type hsv_of_pixel(rhc_pkg::req_type px);
      longint  r, g, b;
      longint  top, bottom, spread;
      longint  hue_acc;
      longint  sat_acc;
      rhc_pkg::rsp_type res;
      r = longint'(px.red);
      g = longint'(px.green);
      b = longint'(px.blue);
      top    = (r > g) ? r : g;
      top    = (b > top) ? b : top;
      bottom = (r < g) ? r : g;
      bottom = (b < bottom) ? b : bottom;
      spread = top - bottom;
      sat_acc = 0;
      hue_acc = 0;
      if (top > 0) begin
         sat_acc = (spread << FB) / top;
         // full saturation (min of zero) clips to all ones
         if (sat_acc > HUE_MASK) sat_acc = HUE_MASK;
      end
      if (spread > 0) begin
         if (r == top)
            hue_acc = (HUE_C17 * (g - b)) / spread;
         else if (g == top)
            hue_acc = HUE_C33 + (HUE_C17 * (b - r)) / spread;
         else
            hue_acc = HUE_C67 + (HUE_C17 * (r - g)) / spread;
         if (hue_acc < 0) hue_acc += HUE_ONE;
      end
      res.hue        = FB'(hue_acc);
      res.saturation = FB'(sat_acc);
      res.brightness = CB'(top);
      return res;
   endfunction

   task automatic queue_pixel(int r, int g, int b);
      rhc_pkg::req_type px;
      px.red   = CB'(r);
      px.green = CB'(g);
      px.blue  = CB'(b);
      pixel_q.push_back(px);
   endtask

   task automatic report_mismatch(string why, rhc_pkg::rsp_type want,
                                  rhc_pkg::rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t hsv %s: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                  $realtime, why, want.hue, want.saturation, want.brightness,
                  got.hue, got.saturation, got.brightness);
   endtask

   // Driver: offers queued pixels with start. A transaction is taken at an
   // edge where start is high and busy is low; its prediction is queued
   // right there. Idle bursts fall at random, with calm stretches in
   // between, and none once the stream nears its end.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            hsv_expected_q.push_back(hsv_of_pixel(req_data));

         if (start && busy) begin
            // not taken yet: hold the transaction as it is
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pixel_q.size() == 0) begin
            start <= 1'b0;
         end else if (calm_left == 0 && pixel_q.size() > QUIET_TAIL &&
                      $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
            if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(20, 150);
            start <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left = calm_left - 1;
            req_data <= pixel_q.pop_front();
            start    <= 1'b1;
         end
      end
   end

   // Monitor: a result is valid for the one cycle rsp_strobe marks, and
   // the receiver has no way to push back, so every strobe is checked.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (hsv_expected_q.size() == 0) begin
            report_mismatch("result with none pending", '0, rsp_data);
         end else begin
            rhc_pkg::rsp_type want;
            want = hsv_expected_q.pop_front();
            if (rsp_data.hue        !== want.hue ||
                rsp_data.saturation !== want.saturation ||
                rsp_data.brightness !== want.brightness)
               report_mismatch("field mismatch", want, rsp_data);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int ch[3];
      int base;
      int mode;

      // directed: black, white, grays, primaries, ties and wraparound
      queue_pixel(0, 0, 0);
      queue_pixel(CHANNEL_MAX, CHANNEL_MAX, CHANNEL_MAX);
      queue_pixel(128, 128, 128);
      queue_pixel(1, 1, 1);
      queue_pixel(CHANNEL_MAX, 0, 0);
      queue_pixel(0, CHANNEL_MAX, 0);
      queue_pixel(0, 0, CHANNEL_MAX);
      queue_pixel(1, 0, 0);
      queue_pixel(0, 1, 0);
      queue_pixel(0, 0, 1);
      queue_pixel(CHANNEL_MAX, 0, 1);             // smallest negative hue
      queue_pixel(CHANNEL_MAX, 0, CHANNEL_MAX - 1); // red max, blue above green
      queue_pixel(CHANNEL_MAX, CHANNEL_MAX, 0);   // red/green tie
      queue_pixel(0, CHANNEL_MAX, CHANNEL_MAX);   // green/blue tie
      queue_pixel(CHANNEL_MAX, 0, CHANNEL_MAX);   // red/blue tie
      queue_pixel(CHANNEL_MAX, CHANNEL_MAX - 1, CHANNEL_MAX - 1);
      queue_pixel(CHANNEL_MAX - 1, CHANNEL_MAX, CHANNEL_MAX - 1);
      queue_pixel(CHANNEL_MAX - 1, CHANNEL_MAX - 1, CHANNEL_MAX);
      queue_pixel(8'hAA, 8'h55, 8'h00);
      queue_pixel(8'h55, 8'hAA, 8'hFF);
      queue_pixel(8'hFF, 8'h80, 8'h7F);
      queue_pixel(2, 1, 0);

      // random pixels, a mix of shapes that stress the divisions
      repeat (RANDOM_PIXELS) begin
         mode = $urandom_range(0, 5);
         base = $urandom_range(0, CHANNEL_MAX);
         for (int i = 0; i < 3; i++) begin
            case (mode)
               0, 1: ch[i] = $urandom_range(0, CHANNEL_MAX);
               2: begin
                  // near gray: tiny spread, large quotients
                  ch[i] = base + $urandom_range(0, 6) - 3;
                  if (ch[i] < 0) ch[i] = 0;
                  if (ch[i] > CHANNEL_MAX) ch[i] = CHANNEL_MAX;
               end
               3: ch[i] = $urandom_range(0, CHANNEL_MAX);
               4: ch[i] = $urandom_range(0, 1) ? base : $urandom_range(0, CHANNEL_MAX);
               default: begin
                  case ($urandom_range(0, 3))
                     0: ch[i] = 0;
                     1: ch[i] = 1;
                     2: ch[i] = CHANNEL_MAX - 1;
                     default: ch[i] = CHANNEL_MAX;
                  endcase
               end
            endcase
         end
         // one channel forced to zero gives full saturation unless the pixel is black
         if (mode == 3) ch[$urandom_range(0, 2)] = 0;
         queue_pixel(ch[0], ch[1], ch[2]);
      end

      // drain: every pixel taken, every result seen, then pipeline settle
      @(negedge clock);
      while (reset || pixel_q.size() > 0 || start) @(negedge clock);
      while (hsv_expected_q.size() > 0) @(negedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (every pixel behind a full
   // idle burst, plus pipeline depth).
   initial begin
      #400_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
